// File: src/sorted_timer_queue_assert.svh
// assertion macros for the sorted timer queue
`ifndef SORTED_TIMER_QUEUE_ASSERT_SVH
`define SORTED_TIMER_QUEUE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define STQ_ASSERT_IMP(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication with the consequent checked in the cycle after the antecedent
`define STQ_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: src/stq_pkg.sv
// shared types and constants of the sorted timer queue
package stq_pkg;
	localparam int NumTimers = 16;
	localparam int SlotW = 4;
	localparam int MaxFires = 16;
	localparam logic [15:0] IdleDelayReset = 16'd100;

	localparam logic [1:0] CmdAdd = 2'd0;
	localparam logic [1:0] CmdRemove = 2'd1;
	localparam logic [1:0] CmdRun = 2'd2;

	localparam logic [1:0] KindAdd = 2'd0;
	localparam logic [1:0] KindRemove = 2'd1;
	localparam logic [1:0] KindFired = 2'd2;
	localparam logic [1:0] KindDone = 2'd3;

	localparam logic [1:0] ErrOk = 2'd0;
	localparam logic [1:0] ErrFull = 2'd1;
	localparam logic [1:0] ErrSlot = 2'd2;

	typedef logic [SlotW-1:0] slot_t;
endpackage

// File: src/sorted_timer_queue.sv
// sorted timer queue top level: timer table, rank keeping and sequencer
// throughput: one word at a time; the next word is taken once the last result is taken
// each walk visits one slot per cycle; the enqueue walk compares 64-bit deadlines, the head searches 4-bit ranks
// reset: asynchronous, active low; clears slot valid bits, sequencer and output valid,
// and loads idle_delay with 100; slot payload storage has no reset
module sorted_timer_queue import stq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] now,
	input  logic [31:0] interval,
	input  logic        oneshot,
	input  logic [3:0]  slot,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [3:0]  timer_slot,
	output logic [63:0] fire_time,
	output logic [63:0] next_delay,
	output logic [1:0]  error,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_ENQ, ST_FIND, ST_FIRE, ST_HEAD, ST_OUT
	} state_t;

	// timer table
	logic [NumTimers-1:0] valid_q;
	logic [NumTimers-1:0] oneshot_q;
	logic [NumTimers-1:0] fired_q;
	logic [31:0] interval_q [NumTimers];
	logic [63:0] deadline_q [NumTimers];
	slot_t rank_q [NumTimers];

	logic [15:0] idle_delay_q;
	state_t state_q;
	logic [63:0] now_q;
	slot_t cur_q;         // slot being placed or fired
	slot_t scan_q;        // walk index
	logic scan_end_q;
	slot_t pos_q;         // count of timers due no later than cur
	logic [4:0] nfired_q;
	logic best_ok_q;
	slot_t best_q;
	logic after_enq_q;    // enqueue belongs to a run

	// output register
	logic out_valid_q;
	logic [1:0] kind_q, error_q;
	slot_t tslot_q;
	logic [63:0] ftime_q, ndelay_q;
	logic last_q;

	// compare unit of the enqueue walk: one deadline against a key per cycle
	logic [63:0] cmp_key;
	logic cmp_le;
	always_comb begin
		cmp_key = deadline_q[cur_q];
		cmp_le = deadline_q[scan_q] <= cmp_key;
	end

	logic free_found;
	slot_t free_slot;
	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int i = NumTimers - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_slot = slot_t'(i);
			end
		end
	end

	logic [63:0] head_diff;
	assign head_diff = deadline_q[best_q] - now_q;

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;
	assign cfg_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign timer_slot = tslot_q;
	assign fire_time = ftime_q;
	assign next_delay = ndelay_q;
	assign error = error_q;
	assign last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			out_valid_q <= 1'b0;
			idle_delay_q <= IdleDelayReset;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				idle_delay_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						now_q <= now;
						case (command)
							CmdAdd: begin
								if (!free_found) begin
									out_valid_q <= 1'b1;
									kind_q <= KindAdd; tslot_q <= '0; error_q <= ErrFull;
									ftime_q <= '0; ndelay_q <= '0; last_q <= 1'b1;
								end else begin
									oneshot_q[free_slot] <= oneshot;
									interval_q[free_slot] <= interval;
									deadline_q[free_slot] <= now + {32'd0, interval};
									cur_q <= free_slot;
									scan_q <= '0; scan_end_q <= 1'b0; pos_q <= '0;
									after_enq_q <= 1'b0;
									state_q <= ST_ENQ;
								end
							end
							CmdRemove: begin
								out_valid_q <= 1'b1;
								kind_q <= KindRemove; tslot_q <= slot;
								ftime_q <= '0; ndelay_q <= '0; last_q <= 1'b1;
								if (!valid_q[slot]) begin
									error_q <= ErrSlot;
								end else begin
									error_q <= ErrOk;
									for (int i = 0; i < NumTimers; i++)
										if (valid_q[i] && rank_q[i] > rank_q[slot])
											rank_q[i] <= rank_q[i] - 1'b1;
									valid_q[slot] <= 1'b0;
								end
							end
							CmdRun: begin
								fired_q <= '0; nfired_q <= '0;
								scan_q <= '0; scan_end_q <= 1'b0; best_ok_q <= 1'b0;
								state_q <= ST_FIND;
							end
							default: ;
						endcase
					end
				end
				ST_ENQ: begin
					// one slot per cycle; counts timers due no later than the new one
					if (!scan_end_q) begin
						if (scan_q != cur_q && valid_q[scan_q] && cmp_le)
							pos_q <= pos_q + 1'b1;
						if (scan_q == slot_t'(NumTimers - 1)) scan_end_q <= 1'b1;
						else scan_q <= scan_q + 1'b1;
					end else begin
						for (int i = 0; i < NumTimers; i++)
							if (slot_t'(i) != cur_q && valid_q[i] && rank_q[i] >= pos_q)
								rank_q[i] <= rank_q[i] + 1'b1;
						rank_q[cur_q] <= pos_q;
						valid_q[cur_q] <= 1'b1;
						if (after_enq_q) begin
							scan_q <= '0; scan_end_q <= 1'b0; best_ok_q <= 1'b0;
							state_q <= ST_FIND;
						end else begin
							out_valid_q <= 1'b1;
							kind_q <= KindAdd; tslot_q <= cur_q; error_q <= ErrOk;
							ftime_q <= '0; ndelay_q <= '0; last_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIND: begin
					// head among valid, not yet fired timers
					if (!scan_end_q) begin
						if (valid_q[scan_q] && !fired_q[scan_q] &&
							(!best_ok_q || rank_q[scan_q] < rank_q[best_q])) begin
							best_ok_q <= 1'b1; best_q <= scan_q;
						end
						if (scan_q == slot_t'(NumTimers - 1)) scan_end_q <= 1'b1;
						else scan_q <= scan_q + 1'b1;
					end else if (!out_valid_q) begin
						if (best_ok_q && nfired_q != 5'(MaxFires) &&
							deadline_q[best_q] <= now_q) begin
							out_valid_q <= 1'b1;
							kind_q <= KindFired; tslot_q <= best_q; error_q <= ErrOk;
							ftime_q <= now_q; ndelay_q <= '0; last_q <= 1'b0;
							fired_q[best_q] <= 1'b1;
							nfired_q <= nfired_q + 1'b1;
							cur_q <= best_q;
							state_q <= ST_FIRE;
						end else begin
							scan_q <= '0; scan_end_q <= 1'b0; best_ok_q <= 1'b0;
							state_q <= ST_HEAD;
						end
					end
				end
				ST_FIRE: begin
					for (int i = 0; i < NumTimers; i++)
						if (slot_t'(i) != cur_q && valid_q[i] && rank_q[i] > rank_q[cur_q])
							rank_q[i] <= rank_q[i] - 1'b1;
					valid_q[cur_q] <= 1'b0;
					if (!oneshot_q[cur_q]) begin
						deadline_q[cur_q] <= now_q + {32'd0, interval_q[cur_q]};
						scan_q <= '0; scan_end_q <= 1'b0; pos_q <= '0;
						after_enq_q <= 1'b1;
						state_q <= ST_ENQ;
					end else begin
						scan_q <= '0; scan_end_q <= 1'b0; best_ok_q <= 1'b0;
						state_q <= ST_FIND;
					end
				end
				ST_HEAD: begin
					// head among all valid timers, then next delay
					if (!scan_end_q) begin
						if (valid_q[scan_q] && (!best_ok_q || rank_q[scan_q] < rank_q[best_q])) begin
							best_ok_q <= 1'b1; best_q <= scan_q;
						end
						if (scan_q == slot_t'(NumTimers - 1)) scan_end_q <= 1'b1;
						else scan_q <= scan_q + 1'b1;
					end else begin
						if (!best_ok_q)
							ndelay_q <= (idle_delay_q > 16'd1) ? {48'd0, idle_delay_q - 16'd1} : 64'd1;
						else if (deadline_q[best_q] > now_q && head_diff > 64'd1)
							ndelay_q <= head_diff - 64'd1;
						else
							ndelay_q <= 64'd1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid_q) begin
						out_valid_q <= 1'b1;
						kind_q <= KindDone; tslot_q <= '0; error_q <= ErrOk;
						ftime_q <= '0; last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: src/stq_checker.sv
// port-level checker for the sorted timer queue
`include "sorted_timer_queue_assert.svh"
module stq_checker import stq_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  command,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [63:0] next_delay,
	input logic        last
);
	`STQ_ASSERT_IMP(a_done_last, clk, arst_n, out_valid && kind == KindDone, last)
	`STQ_ASSERT_IMP(a_fired_not_last, clk, arst_n, out_valid && kind == KindFired, !last)
	`STQ_ASSERT_IMP(a_delay_nonzero, clk, arst_n, out_valid && kind == KindDone,
		next_delay != 64'd0)
	// an accepted known command makes the block busy; an unknown command is dropped and leaves the block ready
	`STQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n,
		in_valid && !in_stall && command <= CmdRun, in_stall)
endmodule

bind sorted_timer_queue stq_checker u_stq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.command(command), .out_valid(out_valid), .out_stall(out_stall), .kind(kind),
	.next_delay(next_delay), .last(last)
);
